>>> rtl/core/xxh_pkg.sv
// shared types, constants and helper functions of the xxh64 block hash
// no dependencies; used by xxh_mul and xxh64_block_hash
package xxh_pkg;

  localparam logic [63:0] P1 = 64'd11400714785074694791;
  localparam logic [63:0] P2 = 64'd14029467366897019727;
  localparam logic [63:0] P3 = 64'd1609587929392839161;
  localparam logic [63:0] P4 = 64'd9650029242287828579;

  localparam int unsigned NUM_LANES = 4;

  // request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WMA,
    S_WMB,
    S_FSUM,
    S_FV2GO,
    S_FV2,
    S_FV1,
    S_FH,
    S_FLEN,
    S_FA2,
    S_FA3,
    S_OUT
  } state_e;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
    rotl64 = (v << r) | (v >> (64 - r));
  endfunction

  // lane rotation used when merging the accumulators
  function automatic logic [63:0] merge_rot(input logic [63:0] v, input logic [1:0] lane);
    case (lane)
      2'd0:    merge_rot = rotl64(v, 1);
      2'd1:    merge_rot = rotl64(v, 7);
      2'd2:    merge_rot = rotl64(v, 12);
      default: merge_rot = rotl64(v, 18);
    endcase
  endfunction

endpackage

>>> rtl/core/xxh_mul.sv
// iterative 64x64 multiplier, low 64 bits of the product, one 32x32 multiply per cycle
// depends on xxh_pkg (mul_req_t)
module xxh_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  xxh_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [63:0]       prod_o
);

  logic        busy_q, busy_d;
  logic [1:0]  ph_q, ph_d;
  logic        done_q, done_d;
  logic [63:0] a_q, b_q;
  logic [63:0] pp_q, sum_q;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;

  // partial products: lo*lo, hi*lo, lo*hi; hi*hi falls outside the low word
  always_comb begin
    case (ph_q)
      2'd0: begin
        op_a = a_q[31:0];
        op_b = b_q[31:0];
      end
      2'd1: begin
        op_a = a_q[63:32];
        op_b = b_q[31:0];
      end
      2'd2: begin
        op_a = a_q[31:0];
        op_b = b_q[63:32];
      end
      default: begin
        op_a = a_q[31:0];
        op_b = b_q[31:0];
      end
    endcase
  end

  assign pp = 64'(op_a) * 64'(op_b);

  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      ph_d   = 2'd0;
    end else if (busy_q) begin
      ph_d = ph_q + 2'd1;
      if (ph_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= 2'd0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end else if (busy_q) begin
      pp_q <= pp;
      case (ph_q)
        2'd1:    sum_q <= pp_q;
        2'd2:    sum_q <= sum_q + {pp_q[31:0], 32'd0};
        2'd3:    sum_q <= sum_q + {pp_q[31:0], 32'd0};
        default: sum_q <= sum_q;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = sum_q;

endmodule

>>> rtl/core/xxh64_block_hash.sv
// top level of the xxh64 block hash: sequencer, accumulators, seed and output register
// depends on xxh_pkg and xxh_mul
//
// xxh64-style hash of one message given as 64-bit little-endian words, one word
// per input transfer with req_type_i low; a transfer with req_type_i high
// finishes the message and yields one hash transfer on the output. word k of a
// message goes into accumulator k mod 4; the first word loads the accumulators
// from the seed then current. msg_bytes_i is only added into the hash, no tail
// bytes are processed, and a zero length gives back the seed. all 64-bit
// multiplies run on a single shared unit built around one 32x32 multiplier,
// so rate is set by that unit: a data word takes two multiplies, a finish with
// nonzero length a merge of the four lanes, twelve multiplies for the lane
// rounds and two for the avalanche, a zero-length finish none. in_stall_o is
// high while an item is in work; a finished hash waits in the output register,
// and the next data word is taken meanwhile. the user must write the seed
// through cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
module xxh64_block_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // seed register
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [63:0] data_word_i,
  input  logic [31:0] msg_bytes_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_o
);

  xxh_pkg::state_e state_q, state_d;

  logic [63:0] seed_q;
  logic [1:0]  lane_q, lane_d;
  logic        fresh_q, fresh_d;
  logic [1:0]  idx_q, idx_d;
  logic [63:0] h_q, h_d;
  logic [31:0] len_q, len_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q;

  // lane accumulators, loaded from the seed by the first word
  logic [63:0] acc_q [xxh_pkg::NUM_LANES];
  logic        acc_init;
  logic        acc_we;
  logic [1:0]  rd_addr;
  logic [63:0] acc_rd;

  xxh_pkg::mul_req_t mul_req;
  logic              mul_done;
  logic [63:0]       mul_p;

  logic [63:0] wsum;
  logic [63:0] lsum;
  logic [63:0] lmix;
  logic        out_load;

  xxh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  // one read port: current lane during a word round, merge index while finishing
  assign rd_addr = (state_q == xxh_pkg::S_WMA) ? lane_q : idx_q;
  assign acc_rd  = acc_q[rd_addr];

  assign wsum = acc_rd + mul_p;
  assign lsum = h_q + {32'd0, len_q};
  assign lmix = lsum ^ (lsum >> 33);

  always_comb begin
    state_d  = state_q;
    lane_d   = lane_q;
    fresh_d  = fresh_q;
    idx_d    = idx_q;
    h_d      = h_q;
    len_d    = len_q;
    mul_req  = '0;
    acc_init = 1'b0;
    acc_we   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      xxh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          acc_init = fresh_q;
          if (!req_type_i) begin
            // data word: first multiply word*P2
            fresh_d     = 1'b0;
            mul_req.start = 1'b1;
            mul_req.a     = data_word_i;
            mul_req.b     = xxh_pkg::P2;
            state_d       = xxh_pkg::S_WMA;
          end else begin
            fresh_d = 1'b1;
            lane_d  = 2'd0;
            idx_d   = 2'd0;
            len_d   = msg_bytes_i;
            if (msg_bytes_i == 32'd0) begin
              h_d     = seed_q;
              state_d = xxh_pkg::S_OUT;
            end else begin
              h_d     = 64'd0;
              state_d = xxh_pkg::S_FSUM;
            end
          end
        end
      end
      xxh_pkg::S_WMA: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xxh_pkg::rotl64(wsum, 31);
          mul_req.b     = xxh_pkg::P1;
          state_d       = xxh_pkg::S_WMB;
        end
      end
      xxh_pkg::S_WMB: begin
        if (mul_done) begin
          acc_we  = 1'b1;
          lane_d  = lane_q + 2'd1;
          state_d = xxh_pkg::S_IDLE;
        end
      end
      xxh_pkg::S_FSUM: begin
        // merge of the rotated lanes, one lane a cycle
        h_d   = h_q + xxh_pkg::merge_rot(acc_rd, idx_q);
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = xxh_pkg::S_FV2GO;
        end
      end
      xxh_pkg::S_FV2GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = acc_rd;
        mul_req.b     = xxh_pkg::P2;
        state_d       = xxh_pkg::S_FV2;
      end
      xxh_pkg::S_FV2: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = xxh_pkg::rotl64(mul_p, 31);
          mul_req.b     = xxh_pkg::P1;
          state_d       = xxh_pkg::S_FV1;
        end
      end
      xxh_pkg::S_FV1: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = h_q ^ mul_p;
          mul_req.b     = xxh_pkg::P1;
          state_d       = xxh_pkg::S_FH;
        end
      end
      xxh_pkg::S_FH: begin
        if (mul_done) begin
          h_d   = mul_p + xxh_pkg::P4;
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin
            state_d = xxh_pkg::S_FLEN;
          end else begin
            state_d = xxh_pkg::S_FV2GO;
          end
        end
      end
      xxh_pkg::S_FLEN: begin
        // length add and first avalanche shift feed the P2 multiply
        mul_req.start = 1'b1;
        mul_req.a     = lmix;
        mul_req.b     = xxh_pkg::P2;
        state_d       = xxh_pkg::S_FA2;
      end
      xxh_pkg::S_FA2: begin
        if (mul_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_p ^ (mul_p >> 29);
          mul_req.b     = xxh_pkg::P3;
          state_d       = xxh_pkg::S_FA3;
        end
      end
      xxh_pkg::S_FA3: begin
        if (mul_done) begin
          h_d     = mul_p ^ (mul_p >> 32);
          state_d = xxh_pkg::S_OUT;
        end
      end
      xxh_pkg::S_OUT: begin
        // wait for a free output register
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = xxh_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = xxh_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && out_stall_i) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xxh_pkg::S_IDLE;
      seed_q      <= 64'd0;
      lane_q      <= 2'd0;
      fresh_q     <= 1'b1;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      fresh_q     <= fresh_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    len_q <= len_d;
    if (out_load) begin
      hash_q <= h_q;
    end
    if (acc_init) begin
      acc_q[0] <= seed_q + xxh_pkg::P1 + xxh_pkg::P2;
      acc_q[1] <= seed_q + xxh_pkg::P2;
      acc_q[2] <= seed_q;
      acc_q[3] <= seed_q - xxh_pkg::P1;
    end else if (acc_we) begin
      acc_q[lane_q] <= mul_p;
    end
  end

  assign in_stall_o  = (state_q != xxh_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

endmodule

>>> rtl/core/xxh_checker.sv
// port-level checks of the xxh64 block hash, bound to the top level
// depends only on the ports of xxh64_block_hash
module xxh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        req_type_i,
  input logic [31:0] msg_bytes_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] hash_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // a waiting hash is held until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hash_o))
    else $error("output hash dropped or changed while stalled");

  // a data word keeps the block busy for its multiplies
  a_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !req_type_i |=> in_stall_o)
    else $error("data word transfer did not occupy the block");

  // a data word never produces a hash
  a_word_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !req_type_i && !out_valid_o |=> !out_valid_o)
    else $error("hash appeared after a data word");

  // a zero-length finish into a free output goes through S_OUT and shows its hash
  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && req_type_i && (msg_bytes_i == 32'd0) && !out_valid_o
      |-> ##2 out_valid_o)
    else $error("zero-length finish did not deliver its hash");

endmodule

bind xxh64_block_hash xxh_checker u_xxh_checker (.*);
